@@ sv/fpc_pkg.sv @@
`timescale 1ns / 1ps

package fpc_pkg;

   // Frame and checksum constants
   localparam int unsigned MAX_PAYLOAD     = 256;
   localparam int unsigned UPDATE_BODY_LEN = 12;
   localparam logic [7:0]  CRC_INIT        = 8'hFF;
   localparam logic [7:0]  CRC_POLY        = 8'h31;

   // Configuration port geometry
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CODE_NACK           = 3'd0,
      CSR_CODE_ACK            = 3'd1,
      CSR_CODE_ID_REQUEST     = 3'd2,
      CSR_CODE_ID_RESPONSE    = 3'd3,
      CSR_CODE_UPDATE_REQUEST = 3'd4,
      CSR_CODE_PROGRAM_DATA   = 3'd5,
      CSR_CODE_CLI_DATA       = 3'd6
   } csr_index_type;

   // Type code reset values
   localparam logic [7:0] RST_CODE_NACK           = 8'd0;
   localparam logic [7:0] RST_CODE_ACK            = 8'd1;
   localparam logic [7:0] RST_CODE_ID_REQUEST     = 8'd2;
   localparam logic [7:0] RST_CODE_ID_RESPONSE    = 8'd3;
   localparam logic [7:0] RST_CODE_UPDATE_REQUEST = 8'd4;
   localparam logic [7:0] RST_CODE_PROGRAM_DATA   = 8'd5;
   localparam logic [7:0] RST_CODE_CLI_DATA       = 8'd6;

   typedef enum logic [3:0] {
      PH_IDLE   = 4'd0,
      PH_DST    = 4'd1,
      PH_TYPE   = 4'd2,
      PH_LEN_HI = 4'd3,
      PH_LEN_LO = 4'd4,
      PH_BODY   = 4'd5,
      PH_HASH   = 4'd6,
      PH_DONE   = 4'd7
   } phase_type;

   typedef enum logic [2:0] {
      KIND_NONE     = 3'd0,
      KIND_BODY     = 3'd1,
      KIND_GOOD     = 3'd2,
      KIND_BAD_HASH = 3'd3,
      KIND_UNKNOWN  = 3'd4,
      KIND_TOO_LONG = 3'd5
   } kind_type;

   // CRC-8, MSB first, one byte
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

@@ sv/fpc_ifs.sv @@
`timescale 1ns / 1ps

// Byte request channel
interface fpc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_start;

   modport source (output valid, output data_byte, output frame_start, input ready);
   modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

// Parse result channel
interface fpc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  result_kind;
   logic [7:0]  body_byte;
   logic [15:0] body_index;
   logic [7:0]  sender_id;
   logic [7:0]  target_id;
   logic [7:0]  frame_type;
   logic [15:0] body_length;
   logic [7:0]  computed_hash;

   modport source (
      output valid, output result_kind, output body_byte, output body_index,
      output sender_id, output target_id, output frame_type,
      output body_length, output computed_hash, input ready
   );
   modport sink (
      input valid, input result_kind, input body_byte, input body_index,
      input sender_id, input target_id, input frame_type,
      input body_length, input computed_hash, output ready
   );
endinterface

@@ sv/frame_parser_crc8_check_core.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Handshake      Payload
// req_ch    in   valid/ready    data_byte[7:0], frame_start
// rsp_ch    out  valid/ready    result_kind[2:0], body_byte, body_index[15:0],
//                               sender_id, target_id, frame_type,
//                               body_length[15:0], computed_hash
// csr_*     in   csr_we         csr_index[2:0], csr_wdata[7:0]
//
// One request in, one response out: the parse step and the CRC-8 byte update
// sit between the parser state registers and the response register, so a byte
// is taken every cycle and its response shows the next cycle.
// Reset (synchronous) returns the parser to idle, the CRC to 0xFF, held fields
// to zero and the type codes to their defaults; no clearing pass.
// A stalled response holds its register; requests keep flowing as long as the
// response register is empty or is being taken in the same cycle.

module frame_parser_crc8_check_core import fpc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   fpc_req_if.sink                req_ch,
   fpc_rsp_if.source              rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // Type code registers
   logic [7:0] code_nack_ff, code_ack_ff, code_id_request_ff, code_id_response_ff;
   logic [7:0] code_update_request_ff, code_program_data_ff, code_cli_data_ff;

   // Parser state
   phase_type   phase_ff, phase_in;
   logic [7:0]  running_crc_ff, running_crc_in;
   logic [7:0]  held_source_ff, held_source_in;
   logic [7:0]  held_destination_ff, held_destination_in;
   logic [7:0]  held_type_ff, held_type_in;
   logic [15:0] held_length_ff, held_length_in;
   logic [15:0] bytes_seen_ff, bytes_seen_in;

   // Response register
   logic        rsp_valid_ff;
   kind_type    rsp_kind_ff, rsp_kind_in;
   logic [7:0]  rsp_body_byte_ff, rsp_body_byte_in;
   logic [15:0] rsp_body_index_ff, rsp_body_index_in;
   logic [7:0]  rsp_source_ff, rsp_destination_ff, rsp_type_ff, rsp_hash_ff;
   logic [15:0] rsp_length_ff;

   logic        req_fire;
   logic [7:0]  b;
   logic        start;
   logic [7:0]  crc_frame_start;
   logic [7:0]  crc_next_byte;
   logic        type_no_body, type_one_byte, type_update, type_len_prefixed;
   logic [15:0] len_word;
   logic        len_too_long;
   logic [15:0] seen_plus_one;
   logic        body_last;

   // Accept whenever the response slot is free or drains this cycle
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign b            = req_ch.data_byte;
   assign start        = req_ch.frame_start;

   assign crc_frame_start = crc8_update(CRC_INIT, b);
   assign crc_next_byte   = crc8_update(running_crc_ff, b);

   // Type decode; the first matching code in list order wins
   assign type_no_body      = (b == code_nack_ff) || (b == code_ack_ff) ||
                              (b == code_id_request_ff);
   assign type_one_byte     = (b == code_id_response_ff);
   assign type_update       = (b == code_update_request_ff);
   assign type_len_prefixed = (b == code_program_data_ff) || (b == code_cli_data_ff);

   // High length byte already sits in held_length_ff[15:8]
   assign len_word     = held_length_ff | {8'h00, b};
   assign len_too_long = len_word > 16'(MAX_PAYLOAD);

   assign seen_plus_one = bytes_seen_ff + 16'd1;
   assign body_last     = seen_plus_one >= held_length_ff;

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (start) begin
         phase_in = PH_DST;
      end else begin
         unique case (phase_ff)
            PH_IDLE:   phase_in = PH_IDLE;
            PH_DST:    phase_in = PH_TYPE;
            PH_TYPE: begin
               priority if (type_no_body)      phase_in = PH_HASH;
               else if (type_one_byte)         phase_in = PH_BODY;
               else if (type_update)           phase_in = PH_BODY;
               else if (type_len_prefixed)     phase_in = PH_LEN_HI;
               else                            phase_in = PH_DONE;
            end
            PH_LEN_HI: phase_in = PH_LEN_LO;
            PH_LEN_LO: begin
               priority if (len_too_long)      phase_in = PH_DONE;
               else if (len_word == 16'd0)     phase_in = PH_HASH;
               else                            phase_in = PH_BODY;
            end
            PH_BODY:   phase_in = body_last ? PH_HASH : PH_BODY;
            PH_HASH:   phase_in = PH_DONE;
            PH_DONE:   phase_in = PH_DONE;
            default:   phase_in = PH_IDLE;
         endcase
      end
   end

   // Held fields, CRC and response contents
   always_comb begin
      running_crc_in      = running_crc_ff;
      held_source_in      = held_source_ff;
      held_destination_in = held_destination_ff;
      held_type_in        = held_type_ff;
      held_length_in      = held_length_ff;
      bytes_seen_in       = bytes_seen_ff;
      rsp_kind_in         = KIND_NONE;
      rsp_body_byte_in    = 8'h00;
      rsp_body_index_in   = 16'h0000;
      if (start) begin
         // Restart: drop any frame in progress silently
         held_source_in      = b;
         held_destination_in = 8'h00;
         held_type_in        = 8'h00;
         held_length_in      = 16'h0000;
         bytes_seen_in       = 16'h0000;
         running_crc_in      = crc_frame_start;
      end else begin
         unique case (phase_ff)
            PH_DST: begin
               held_destination_in = b;
               running_crc_in      = crc_next_byte;
            end
            PH_TYPE: begin
               held_type_in   = b;
               running_crc_in = crc_next_byte;
               bytes_seen_in  = 16'h0000;
               priority if (type_no_body) begin
                  held_length_in = 16'h0000;
               end else if (type_one_byte) begin
                  held_length_in = 16'd1;
               end else if (type_update) begin
                  held_length_in = 16'(UPDATE_BODY_LEN);
               end else if (type_len_prefixed) begin
                  held_length_in = 16'h0000;
               end else begin
                  held_length_in = 16'h0000;
                  rsp_kind_in    = KIND_UNKNOWN;
               end
            end
            PH_LEN_HI: begin
               held_length_in = {b, 8'h00};
               running_crc_in = crc_next_byte;
            end
            PH_LEN_LO: begin
               held_length_in = len_word;
               running_crc_in = crc_next_byte;
               if (len_too_long) begin
                  rsp_kind_in = KIND_TOO_LONG;
               end
            end
            PH_BODY: begin
               rsp_kind_in       = KIND_BODY;
               rsp_body_byte_in  = b;
               rsp_body_index_in = bytes_seen_ff;
               running_crc_in    = crc_next_byte;
               bytes_seen_in     = seen_plus_one;
            end
            PH_HASH: begin
               // The hash byte never enters the CRC
               rsp_kind_in = (b == running_crc_ff) ? KIND_GOOD : KIND_BAD_HASH;
            end
            default: begin
               // Idle or after a verdict: ignore bytes outside a frame
            end
         endcase
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         code_nack_ff           <= RST_CODE_NACK;
         code_ack_ff            <= RST_CODE_ACK;
         code_id_request_ff     <= RST_CODE_ID_REQUEST;
         code_id_response_ff    <= RST_CODE_ID_RESPONSE;
         code_update_request_ff <= RST_CODE_UPDATE_REQUEST;
         code_program_data_ff   <= RST_CODE_PROGRAM_DATA;
         code_cli_data_ff       <= RST_CODE_CLI_DATA;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_CODE_NACK:           code_nack_ff           <= csr_wdata;
            CSR_CODE_ACK:            code_ack_ff            <= csr_wdata;
            CSR_CODE_ID_REQUEST:     code_id_request_ff     <= csr_wdata;
            CSR_CODE_ID_RESPONSE:    code_id_response_ff    <= csr_wdata;
            CSR_CODE_UPDATE_REQUEST: code_update_request_ff <= csr_wdata;
            CSR_CODE_PROGRAM_DATA:   code_program_data_ff   <= csr_wdata;
            CSR_CODE_CLI_DATA:       code_cli_data_ff       <= csr_wdata;
            default: begin
               // Drop writes to unmapped indexes
            end
         endcase
      end
   end

   // Parser state: advance only on an accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff            <= PH_IDLE;
         running_crc_ff      <= CRC_INIT;
         held_source_ff      <= 8'h00;
         held_destination_ff <= 8'h00;
         held_type_ff        <= 8'h00;
         held_length_ff      <= 16'h0000;
         bytes_seen_ff       <= 16'h0000;
      end else if (req_fire) begin
         phase_ff            <= phase_in;
         running_crc_ff      <= running_crc_in;
         held_source_ff      <= held_source_in;
         held_destination_ff <= held_destination_in;
         held_type_ff        <= held_type_in;
         held_length_ff      <= held_length_in;
         bytes_seen_ff       <= bytes_seen_in;
      end
   end

   // Response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Response payload: load with each accepted request, hold otherwise
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_kind_ff        <= rsp_kind_in;
         rsp_body_byte_ff   <= rsp_body_byte_in;
         rsp_body_index_ff  <= rsp_body_index_in;
         rsp_source_ff      <= held_source_in;
         rsp_destination_ff <= held_destination_in;
         rsp_type_ff        <= held_type_in;
         rsp_length_ff      <= held_length_in;
         rsp_hash_ff        <= running_crc_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.result_kind    = rsp_kind_ff;
   assign rsp_ch.body_byte      = rsp_body_byte_ff;
   assign rsp_ch.body_index     = rsp_body_index_ff;
   assign rsp_ch.sender_id      = rsp_source_ff;
   assign rsp_ch.target_id      = rsp_destination_ff;
   assign rsp_ch.frame_type     = rsp_type_ff;
   assign rsp_ch.body_length    = rsp_length_ff;
   assign rsp_ch.computed_hash  = rsp_hash_ff;

   // Every accepted request leaves a response behind
   a_req_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   // Body phase only runs with a legal, nonzero length
   a_body_len_legal: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BODY) |->
         (held_length_ff != 16'h0000) && (held_length_ff <= 16'(MAX_PAYLOAD)) &&
         (bytes_seen_ff < held_length_ff))
      else $error("body phase with bad length or count");

   // A body byte response always lies inside the announced body
   a_body_index_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_kind_ff == KIND_BODY) |-> (rsp_body_index_ff < rsp_length_ff))
      else $error("body index beyond body length");

   // Non-body responses carry zero byte and index
   a_non_body_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_kind_ff != KIND_BODY) |->
         (rsp_body_byte_ff == 8'h00) && (rsp_body_index_ff == 16'h0000))
      else $error("non-body response with body data");

endmodule
